// ----- hw/rtl/ckc_pkg.sv -----
// Shared types, constants and the keyword table of the C keyword counter.
// Used by ckc_scanner and c_keyword_counter; no dependencies of its own.
`default_nettype none

package ckc_pkg;

    // Sizes of the block.
    localparam int NUM_KEYWORDS = 32;
    localparam int MAX_WORD     = 20;
    localparam int COUNT_BITS   = 16;
    localparam int KEY_CHARS    = 8;

    localparam int KW_IDX_W = $clog2(NUM_KEYWORDS);
    localparam int LEN_W    = $clog2(MAX_WORD);
    localparam int POS_W    = $clog2(KEY_CHARS);

    // Action codes of an input word.
    localparam logic [1:0] ACT_TEXT  = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Reply kinds of a result word.
    localparam logic REPLY_HIT  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] text_byte;
        logic [4:0] key_index;
    } in_word_t;

    typedef struct packed {
        logic        reply_kind;
        logic [4:0]  keyword_number;
        logic [15:0] keyword_count;
    } out_word_t;

    // Counter operation requested by the scanner.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_HIT,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [KW_IDX_W-1:0] idx;
    } req_t;

    // Keywords in alphabetical order, left-justified and padded with spaces.
    localparam logic [8*KEY_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "auto    ", "break   ", "case    ", "char    ",
        "const   ", "continue", "default ", "do      ",
        "double  ", "else    ", "enum    ", "extern  ",
        "float   ", "for     ", "goto    ", "if      ",
        "int     ", "long    ", "register", "return  ",
        "short   ", "signed  ", "sizeof  ", "static  ",
        "struct  ", "switch  ", "typedef ", "union   ",
        "unsigned", "void    ", "volatile", "while   "
    };

    localparam logic [LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
        5'd4, 5'd5, 5'd4, 5'd4, 5'd5, 5'd8, 5'd7, 5'd2,
        5'd6, 5'd4, 5'd4, 5'd6, 5'd5, 5'd3, 5'd4, 5'd2,
        5'd3, 5'd4, 5'd8, 5'd6, 5'd5, 5'd6, 5'd6, 5'd6,
        5'd6, 5'd6, 5'd7, 5'd5, 5'd8, 5'd4, 5'd8, 5'd5
    };

    // Character at position pos of keyword k.
    function automatic logic [7:0] kw_char(input int k, input int pos);
        logic [8*KEY_CHARS-1:0] text;
        text = KW_TEXT[k];
        return text[8*(KEY_CHARS-1-pos) +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ckc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module ckc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ckc_scanner.sv -----
// Text scanner: tracks word and string state, collects word characters and
// matches a finished word against the keyword table. Depends on ckc_pkg.
`default_nettype none

module ckc_scanner
    import ckc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_word_t item,
    output req_t          req
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_WORD,
        M_STRING
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       chars_reg [KEY_CHARS];

    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    logic [7:0]       c;
    logic             is_letter, is_alnum, is_quote;
    logic             finish;
    logic             match_hit;
    logic [KW_IDX_W-1:0] match_idx;

    // Character classes; bytes of 128 and above fall in none of them.
    assign c         = item.text_byte;
    assign is_letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    assign is_alnum  = is_letter || (c >= CH_DIG_0 && c <= CH_DIG_9);
    assign is_quote  = (c == CH_QUOTE);

    // Parallel compare of the open word against every keyword.
    always_comb
    begin
        logic eq;
        match_hit = 1'b0;
        match_idx = '0;
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            eq = (len_reg == KW_LEN[k]);
            for (int p = 0; p < KEY_CHARS; p++)
            begin
                if (LEN_W'(p) < len_reg && chars_reg[p] != kw_char(k, p))
                begin
                    eq = 1'b0;
                end
            end
            if (eq)
            begin
                match_hit = 1'b1;
                match_idx = KW_IDX_W'(k);
            end
        end
    end

    // Next scan state and the counter request of the current word.
    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        wr_en     = 1'b0;
        wr_pos    = '0;
        finish    = 1'b0;
        req.op    = OP_NONE;
        req.idx   = item.key_index;

        case (item.action)
            ACT_TEXT:
            begin
                if (mode_reg == M_STRING)
                begin
                    if (is_quote)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                else if (mode_reg == M_WORD && is_alnum)
                begin
                    if (len_reg < LEN_W'(MAX_WORD - 1))
                    begin
                        if (len_reg < LEN_W'(KEY_CHARS))
                        begin
                            wr_en  = 1'b1;
                            wr_pos = len_reg[POS_W-1:0];
                        end
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        // Over-long word: the extra character ends it and is dropped.
                        finish    = 1'b1;
                        mode_next = M_IDLE;
                        len_next  = '0;
                    end
                end
                else
                begin
                    // Outside a word, or a byte that ends the open word.
                    finish    = (mode_reg == M_WORD);
                    mode_next = M_IDLE;
                    len_next  = '0;
                    if (is_letter)
                    begin
                        wr_en     = 1'b1;
                        wr_pos    = '0;
                        len_next  = LEN_W'(1);
                        mode_next = M_WORD;
                    end
                    else if (is_quote)
                    begin
                        mode_next = M_STRING;
                    end
                end
            end
            ACT_FLUSH:
            begin
                finish    = (mode_reg == M_WORD);
                mode_next = M_IDLE;
                len_next  = '0;
            end
            ACT_READ:
            begin
                req.op = OP_READ;
            end
            default:
            begin
            end
        endcase

        if (finish && match_hit)
        begin
            req.op  = OP_HIT;
            req.idx = match_idx;
        end
    end

    // Scan state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

    // Word characters; only positions written in the current word are compared.
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            chars_reg[wr_pos] <= c;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/c_keyword_counter.sv -----
// Top level of the C keyword counter: scanner, counter memory with its
// read-modify-write stage, and the result register. Depends on ckc_pkg,
// ckc_scanner and ckc_ram.
//
// The block takes one input word per clock cycle while item_stall is low. A
// text byte or end-of-text word is scanned in the cycle it is accepted; if it
// closes a keyword, the counter memory is read in that cycle and the word
// enters the update stage. When that stage moves on, the saturating increment
// is written back and the result word is loaded into the result register. A
// counter read takes the same path. The rate is set by the single counter
// memory, which does one read and one write per cycle; a one-entry forward
// covers a counter that is read at the same edge its updated value is written.
// Counters are cleared at reset by per-entry valid bits, so the block needs no
// clearing pass and is ready right after reset. Words that cause no result
// produce nothing.
`default_nettype none

module c_keyword_counter
    import ckc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_word_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_word_t      result
);

    req_t                  req;
    logic                  accept;
    logic                  load_s1;
    logic                  s1_adv;

    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    logic [KW_IDX_W-1:0]   s1_idx_reg;

    logic                  fwd_valid_reg, fwd_valid_next;
    logic [KW_IDX_W-1:0]   fwd_idx_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [NUM_KEYWORDS-1:0] cnt_valid_reg;

    logic                  result_valid_reg;
    out_word_t             result_reg;

    logic                  ram_we;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;

    // Handshake: hold the input only when the update stage cannot move on.
    assign item_stall = s1_valid_reg && result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign load_s1    = accept && (req.op != OP_NONE);
    assign s1_adv     = s1_valid_reg && !(result_valid_reg && result_stall);

    ckc_scanner u_scanner (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .req    (req)
    );

    ckc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_KEYWORDS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (inc_count),
        .re    (load_s1),
        .raddr (req.idx),
        .rdata (ram_rdata)
    );

    // Current counter value: forwarded write, memory data, or zero if never written.
    always_comb
    begin
        if (fwd_valid_reg && fwd_idx_reg == s1_idx_reg)
        begin
            cur_count = fwd_data_reg;
        end
        else if (cnt_valid_reg[s1_idx_reg])
        begin
            cur_count = ram_rdata;
        end
        else
        begin
            cur_count = '0;
        end
        inc_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
    end

    assign ram_we = s1_adv && (s1_op_reg == OP_HIT);

    // The forward holds only for a read issued at the same edge as the write.
    always_comb
    begin
        if (load_s1)
        begin
            fwd_valid_next = ram_we;
        end
        else if (s1_adv)
        begin
            fwd_valid_next = 1'b0;
        end
        else
        begin
            fwd_valid_next = fwd_valid_reg;
        end
    end

    // Update stage and result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            cnt_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            fwd_valid_reg <= fwd_valid_next;
            if (ram_we)
            begin
                cnt_valid_reg[s1_idx_reg] <= 1'b1;
            end
            if (s1_adv)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Update stage and result payload.
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_op_reg    <= req.op;
            s1_idx_reg   <= req.idx;
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= inc_count;
        end
        if (s1_adv)
        begin
            result_reg.reply_kind     <= (s1_op_reg == OP_HIT) ? REPLY_HIT : REPLY_READ;
            result_reg.keyword_number <= s1_idx_reg;
            result_reg.keyword_count  <= (s1_op_reg == OP_HIT) ? inc_count : cur_count;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A forward is only armed while a word sits in the update stage.
    a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forward armed with empty update stage");

    // A counted keyword always reports a nonzero count.
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.reply_kind == REPLY_HIT)
            |-> (result_reg.keyword_count != '0))
        else $error("keyword hit reported with zero count");

    // After a counter write the entry is marked as holding data.
    a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> cnt_valid_reg[$past(s1_idx_reg)])
        else $error("written counter not marked valid");

    // Input is held only while a word waits in the update stage behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ----- tb/sv/c_keyword_counter_tb.sv -----
// Testbench of the C keyword counter: streams text, end-of-text and counter read
// words, predicts every keyword hit and read reply, and checks them in order.
// Depends on ckc_pkg and the c_keyword_counter RTL.

module c_keyword_counter_tb;
    import ckc_pkg::*;

    // Action value that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 9;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          RANDOM_WORDS  = 1600;
    localparam int          PHASE_WORDS   = 200;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          HOLD_READS    = 40;
    localparam int          MAX_REPORTS   = 40;
    localparam logic [15:0] COUNT_TOP     = 16'hFFFF;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_STRING
    } scan_mode_t;

    // Keyword tally: tracks the scanner and counters and holds the replies due.
    class keyword_tally;
        scan_mode_t  mode;
        logic [7:0]  chars [KEY_CHARS];
        int unsigned word_len;
        logic [15:0] counts [NUM_KEYWORDS];
        string       names [NUM_KEYWORDS];
        out_word_t   replies_due [$];
        int          errors;

        function new();
            names = '{"auto", "break", "case", "char", "const", "continue", "default",
                      "do", "double", "else", "enum", "extern", "float", "for", "goto",
                      "if", "int", "long", "register", "return", "short", "signed",
                      "sizeof", "static", "struct", "switch", "typedef", "union",
                      "unsigned", "void", "volatile", "while"};
            mode = SCAN_IDLE;
            word_len = 0;
            errors = 0;
            foreach (counts[i])
                counts[i] = '0;
            foreach (chars[i])
                chars[i] = '0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_DIG_0 && c <= CH_DIG_9;
        endfunction

        // Match the open word against the keywords and count a hit.
        function void close_word();
            int        hit;
            bit        same;
            out_word_t r;
            hit = -1;
            if (word_len <= KEY_CHARS) begin
                for (int k = 0; k < NUM_KEYWORDS; k++) begin
                    if (names[k].len() == word_len) begin
                        same = 1'b1;
                        for (int p = 0; p < word_len; p++)
                            if (chars[p] != names[k][p])
                                same = 1'b0;
                        if (same)
                            hit = k;
                    end
                end
            end
            mode = SCAN_IDLE;
            word_len = 0;
            if (hit >= 0) begin
                if (counts[hit] != COUNT_TOP)
                    counts[hit]++;
                r.reply_kind = REPLY_HIT;
                r.keyword_number = 5'(hit);
                r.keyword_count = counts[hit];
                replies_due.push_back(r);
            end
        endfunction

        // A byte seen outside a word or string.
        function void start_from_idle(logic [7:0] c);
            if (is_letter(c)) begin
                chars[0] = c;
                word_len = 1;
                mode = SCAN_WORD;
            end else if (c == CH_QUOTE) begin
                mode = SCAN_STRING;
            end
        endfunction

        // Note an accepted input word and queue the reply it causes.
        function void note_word(in_word_t w);
            out_word_t r;
            case (w.action)
                ACT_TEXT: begin
                    case (mode)
                        SCAN_STRING: begin
                            if (w.text_byte == CH_QUOTE)
                                mode = SCAN_IDLE;
                        end
                        SCAN_WORD: begin
                            if (is_letter(w.text_byte) || is_digit(w.text_byte)) begin
                                if (word_len < MAX_WORD - 1) begin
                                    if (word_len < KEY_CHARS)
                                        chars[word_len] = w.text_byte;
                                    word_len++;
                                end else begin
                                    close_word();
                                end
                            end else begin
                                close_word();
                                start_from_idle(w.text_byte);
                            end
                        end
                        default: start_from_idle(w.text_byte);
                    endcase
                end
                ACT_FLUSH: begin
                    if (mode == SCAN_WORD)
                        close_word();
                    mode = SCAN_IDLE;
                    word_len = 0;
                end
                ACT_READ: begin
                    r.reply_kind = REPLY_READ;
                    r.keyword_number = w.key_index;
                    r.keyword_count = (w.key_index < NUM_KEYWORDS) ? counts[w.key_index] : '0;
                    replies_due.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        // Check an accepted result word against the oldest reply due.
        function void check_result(out_word_t got);
            out_word_t want;
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result word with nothing expected: kind %0d keyword %0d count %0d",
                           got.reply_kind, got.keyword_number, got.keyword_count);
                return;
            end
            want = replies_due.pop_front();
            compare_field("reply_kind", 16'(want.reply_kind), 16'(got.reply_kind));
            compare_field("keyword_number", 16'(want.keyword_number),
                          16'(got.keyword_number));
            compare_field("keyword_count", want.keyword_count, got.keyword_count);
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      result_valid;
    logic      result_stall;
    out_word_t result;

    keyword_tally tally = new();
    int           max_in_gap = 8;
    int           max_out_gap = 8;
    bit           hold_request = 1'b0;
    int           sent_count = 0;
    int           quiet_cycles = 0;

    c_keyword_counter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if ((item_valid === 1'b1 && item_stall === 1'b0) ||
                (result_valid === 1'b1 && result_stall === 1'b0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side: random stalls, one long hold on request, check every word.
    initial
    begin
        int hold;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = HOLD_CYCLES;
            end else begin
                hold = $urandom_range(max_out_gap, 0);
            end
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
            tally.check_result(result);
        end
    end

    function automatic in_word_t make_word(logic [1:0] act, logic [7:0] ch, logic [4:0] idx);
        in_word_t w;
        w.action = act;
        w.text_byte = ch;
        w.key_index = idx;
        return w;
    endfunction

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = $urandom_range(max_in_gap, 0);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do @(posedge clk); while (item_stall !== 1'b0);
        tally.note_word(w);
        if (w.action != ACT_UNUSED)
            sent_count++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_word(make_word(ACT_TEXT, ch, 5'($urandom_range(31))));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_flush();
        send_word(make_word(ACT_FLUSH, 8'($urandom_range(255)), 5'($urandom_range(31))));
    endtask

    task automatic send_read(input logic [4:0] idx);
        send_word(make_word(ACT_READ, 8'($urandom_range(255)), idx));
    endtask

    function automatic logic [7:0] random_letter();
        int pick;
        pick = $urandom_range(51);
        return (pick < 26) ? CH_UP_A + 8'(pick) : CH_LO_A + 8'(pick - 26);
    endfunction

    function automatic logic [7:0] random_alnum();
        int pick;
        pick = $urandom_range(61);
        return (pick < 10) ? CH_DIG_0 + 8'(pick) : random_letter();
    endfunction

    // Byte that ends a word: punctuation, control, high bytes, rarely a quote.
    function automatic logic [7:0] random_separator();
        int pick;
        pick = $urandom_range(19);
        case (pick)
            0, 1, 2, 3, 4, 5: return " ";
            6, 7:             return ";";
            8, 9:             return "(";
            10:               return ",";
            11:               return 8'h0A;
            12:               return 8'h00;
            13:               return CH_QUOTE;
            14, 15:           return 8'($urandom_range(255, 128));
            default:          return 8'($urandom_range(47, 33)) == CH_QUOTE ? "." :
                                     8'($urandom_range(47, 33));
        endcase
    endfunction

    // One random piece of text or command, mostly well-formed keyword text.
    task automatic send_random_piece();
        int         pick;
        int         n;
        string      s;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 45) begin
            // A keyword, sometimes with a wrong case or a trailing character.
            s = tally.names[$urandom_range(NUM_KEYWORDS - 1)];
            if ($urandom_range(9) == 0)
                s[0] = byte'(s[0] - 32);
            send_text(s);
            if ($urandom_range(9) == 0)
                send_char(random_alnum());
            if ($urandom_range(4) == 0)
                send_flush();
            else
                send_char(random_separator());
        end else if (pick < 60) begin
            // Random identifier; some reach or pass the word length limit.
            n = ($urandom_range(3) == 0) ? $urandom_range(MAX_WORD + 1, MAX_WORD - 2) :
                $urandom_range(12, 1);
            send_char(random_letter());
            repeat (n - 1) send_char(random_alnum());
            send_char(random_separator());
        end else if (pick < 70) begin
            // Quoted string whose content may hold keywords.
            send_char(CH_QUOTE);
            if ($urandom_range(1) == 0) begin
                send_text(tally.names[$urandom_range(NUM_KEYWORDS - 1)]);
            end else begin
                repeat ($urandom_range(6)) begin
                    ch = 8'($urandom_range(255));
                    send_char(ch == CH_QUOTE ? " " : ch);
                end
            end
            if ($urandom_range(7) == 0)
                send_flush();
            else
                send_char(CH_QUOTE);
        end else if (pick < 82) begin
            send_read(5'($urandom_range(31)));
        end else if (pick < 88) begin
            // Digits outside a word are skipped.
            repeat ($urandom_range(3, 1)) send_char(CH_DIG_0 + 8'($urandom_range(9)));
        end else begin
            // Noise: any action with any byte and index.
            repeat ($urandom_range(4, 1))
                send_word(make_word(2'($urandom_range(3)), 8'($urandom_range(255)),
                                    5'($urandom_range(31))));
        end
    endtask

    // Stimulus.
    initial
    begin
        int  phase;
        bit  pressure_done;
        pressure_done = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every action, and the special cases.
        send_text("while");
        send_char(8'hFF);
        send_text("\"do\"");
        send_text("do");
        send_flush();
        send_text("if\"x");
        send_flush();
        send_read(5'd31);
        send_read(5'd0);
        send_read(5'd15);
        send_word(make_word(ACT_UNUSED, 8'hA5, 5'd10));
        send_char(8'h00);
        send_text("9;");

        // Random text in phases with and without idling on either side.
        sent_count = 0;
        while (sent_count < RANDOM_WORDS) begin
            phase = sent_count / PHASE_WORDS;
            max_in_gap = (phase % 3 == 2) ? 0 : 8;
            max_out_gap = (phase % 3 == 1) ? 0 : 8;
            if (!pressure_done && sent_count >= 3 * PHASE_WORDS) begin
                // Long hold on the result side while reads keep coming.
                pressure_done = 1'b1;
                hold_request = 1'b1;
                max_in_gap = 0;
                repeat (HOLD_READS) send_read(5'($urandom_range(31)));
            end
            send_random_piece();
        end

        // Final reads of counters 7 and 0 with no idling.
        max_in_gap = 0;
        max_out_gap = 0;
        send_read(5'd7);
        send_read(5'd0);
        item_valid <= 1'b0;

        // Drain and report.
        while (tally.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tally.errors == 0 && tally.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
